// ===== design/cpb_pkg.sv =====
// ---------------------------------------------------------------------------
// cpb_pkg
// shared widths, register codes and helpers for the clipped palette blitter
// ---------------------------------------------------------------------------
package cpb_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int DIM_W     = 13;                  // width and height registers
   localparam int POS_W     = $clog2(MAX_DIM);     // source column and row counters
   localparam int OFS_W     = 14;                  // signed destination offsets
   localparam int SUM_W     = OFS_W + 1;           // offset plus position
   localparam int PROD_W    = POS_W + DIM_W;       // row times width

   localparam int PAL_DEPTH = 256;
   localparam int PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
   localparam int IDX_W     = 8;
   localparam int COLOR_W   = 32;
   localparam int ADDR_W    = 24;

   localparam int REQ_DW    = 48;                  // slot, color, pixel index
   localparam int RSP_DW    = 56;                  // address, color

   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 14;

   localparam logic [CSR_AW-1:0] REG_DEST_WIDTH    = 3'd0;
   localparam logic [CSR_AW-1:0] REG_DEST_HEIGHT   = 3'd1;
   localparam logic [CSR_AW-1:0] REG_DEST_LEFT     = 3'd2;
   localparam logic [CSR_AW-1:0] REG_DEST_TOP      = 3'd3;
   localparam logic [CSR_AW-1:0] REG_SOURCE_WIDTH  = 3'd4;
   localparam logic [CSR_AW-1:0] REG_SOURCE_HEIGHT = 3'd5;

   localparam logic OP_PALETTE_LOAD = 1'b0;
   localparam logic OP_PIXEL        = 1'b1;

   // clip result of one pixel, passed from the walker to the address stages
   typedef struct packed {
      logic             written;
      logic             image_end;
      logic             idx_ok;
      logic [POS_W-1:0] dest_x;
      logic [POS_W-1:0] dest_y;
   } pix_type;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] lim;
      lim = DIM_W'(MAX_DIM);
      return (v > lim) ? lim : v;
   endfunction

endpackage

// ===== design/cpb_palette.sv =====
// ---------------------------------------------------------------------------
// cpb_palette
// palette store: one write port for loads, one registered read for pixels
// ---------------------------------------------------------------------------
module cpb_palette (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [cpb_pkg::IDX_W-1:0]   wr_slot,
   input  logic [cpb_pkg::COLOR_W-1:0] wr_color,
   input  logic                        rd_en,
   input  logic [cpb_pkg::IDX_W-1:0]   rd_index,
   output logic [cpb_pkg::COLOR_W-1:0] rd_color
);

   logic [cpb_pkg::COLOR_W-1:0] mem [cpb_pkg::PAL_DEPTH];
   logic [cpb_pkg::COLOR_W-1:0] rd_color_ff;

   always_ff @(posedge clock) begin
      if (wr_en && ({1'b0, wr_slot} < (cpb_pkg::IDX_W+1)'(cpb_pkg::PAL_DEPTH))) begin
         mem[wr_slot[cpb_pkg::PAL_AW-1:0]] <= wr_color;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_color_ff <= mem[rd_index[cpb_pkg::PAL_AW-1:0]];
      end
   end

   assign rd_color = rd_color_ff;

endmodule

// ===== design/cpb_walker.sv =====
// ---------------------------------------------------------------------------
// cpb_walker
// source position counters, offset and clip test, first pipeline stage
// ---------------------------------------------------------------------------
module cpb_walker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pix_acc,
   input  logic                        s1_ready,
   input  logic [cpb_pkg::DIM_W-1:0]   dw,
   input  logic [cpb_pkg::DIM_W-1:0]   dh,
   input  logic [cpb_pkg::DIM_W-1:0]   sw,
   input  logic [cpb_pkg::DIM_W-1:0]   sh,
   input  logic [cpb_pkg::OFS_W-1:0]   dest_left,
   input  logic [cpb_pkg::OFS_W-1:0]   dest_top,
   input  logic [cpb_pkg::IDX_W-1:0]   pixel_value,
   output logic                        adv,
   output logic                        s1_valid,
   output cpb_pkg::pix_type            s1_pix
);

   logic [cpb_pkg::POS_W-1:0] col_ff, col_in;
   logic [cpb_pkg::POS_W-1:0] row_ff, row_in;
   logic                      v1_ff, v1_in;
   cpb_pkg::pix_type          pix_ff, pix_in;

   logic                      empty;
   logic [cpb_pkg::DIM_W-1:0] col_inc, row_inc;
   logic [cpb_pkg::SUM_W-1:0] ox, oy;
   logic                      in_x, in_y;
   logic                      last_col, last_row;

   assign adv = !v1_ff || s1_ready;

   always_comb begin
      empty    = (sw == '0) || (sh == '0);
      col_inc  = {1'b0, col_ff} + cpb_pkg::DIM_W'(1);
      row_inc  = {1'b0, row_ff} + cpb_pkg::DIM_W'(1);
      last_col = (col_inc >= sw);
      last_row = (row_inc >= sh);

      // signed offset plus unsigned position
      ox   = {dest_left[cpb_pkg::OFS_W-1], dest_left} + {3'b000, col_ff};
      oy   = {dest_top[cpb_pkg::OFS_W-1], dest_top} + {3'b000, row_ff};
      in_x = !ox[cpb_pkg::SUM_W-1] && (ox[cpb_pkg::OFS_W-1:0] < {1'b0, dw});
      in_y = !oy[cpb_pkg::SUM_W-1] && (oy[cpb_pkg::OFS_W-1:0] < {1'b0, dh});

      pix_in.written   = !empty && in_x && in_y;
      pix_in.image_end = empty || (last_col && last_row);
      pix_in.idx_ok    = ({1'b0, pixel_value} < (cpb_pkg::IDX_W+1)'(cpb_pkg::PAL_DEPTH));
      pix_in.dest_x    = ox[cpb_pkg::POS_W-1:0];
      pix_in.dest_y    = oy[cpb_pkg::POS_W-1:0];

      col_in = col_ff;
      row_in = row_ff;
      if (pix_acc) begin
         if (empty) begin
            col_in = '0;
            row_in = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_inc[cpb_pkg::POS_W-1:0];
         end else begin
            col_in = col_inc[cpb_pkg::POS_W-1:0];
         end
      end

      v1_in = adv ? pix_acc : v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         v1_ff  <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         v1_ff  <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pix_ff <= pix_in;
      end
   end

   assign s1_valid = v1_ff;
   assign s1_pix   = pix_ff;

endmodule

// ===== design/cpb_addr.sv =====
// ---------------------------------------------------------------------------
// cpb_addr
// row times width product, column add and the output register
// ---------------------------------------------------------------------------
module cpb_addr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        s1_valid,
   input  cpb_pkg::pix_type            s1_pix,
   input  logic [cpb_pkg::COLOR_W-1:0] s1_color,
   input  logic [cpb_pkg::DIM_W-1:0]   dw,
   output logic                        s1_ready,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic                        out_written,
   output logic [cpb_pkg::ADDR_W-1:0]  out_address,
   output logic [cpb_pkg::COLOR_W-1:0] out_color,
   output logic                        out_end
);

   logic                         v2_ff, v2_in;
   logic [cpb_pkg::PROD_W-1:0]   prod_ff;
   logic [cpb_pkg::POS_W-1:0]    x2_ff;
   logic                         wr2_ff, end2_ff;
   logic [cpb_pkg::COLOR_W-1:0]  color2_ff;

   logic                         v3_ff, v3_in;
   logic                         wr3_ff, end3_ff;
   logic [cpb_pkg::ADDR_W-1:0]   addr3_ff;
   logic [cpb_pkg::COLOR_W-1:0]  color3_ff;

   logic                         en2, en3;
   logic [cpb_pkg::PROD_W-1:0]   prod_in, sum;

   always_comb begin
      en3      = !v3_ff || out_ready;
      en2      = !v2_ff || en3;
      s1_ready = en2;
      prod_in  = {{cpb_pkg::DIM_W{1'b0}}, s1_pix.dest_y} * {{cpb_pkg::POS_W{1'b0}}, dw};
      sum      = prod_ff + {{cpb_pkg::DIM_W{1'b0}}, x2_ff};
      v2_in    = en2 ? s1_valid : v2_ff;
      v3_in    = en3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         prod_ff   <= prod_in;
         x2_ff     <= s1_pix.dest_x;
         wr2_ff    <= s1_pix.written;
         end2_ff   <= s1_pix.image_end;
         color2_ff <= s1_pix.idx_ok ? s1_color : '0;
      end
      if (en3) begin
         wr3_ff    <= wr2_ff;
         end3_ff   <= end2_ff;
         addr3_ff  <= wr2_ff ? sum[cpb_pkg::ADDR_W-1:0] : '0;
         color3_ff <= color2_ff;
      end
   end

   assign out_valid   = v3_ff;
   assign out_written = wr3_ff;
   assign out_address = addr3_ff;
   assign out_color   = color3_ff;
   assign out_end     = end3_ff;

endmodule

// ===== design/clipped_palette_blitter_top.sv =====
// ---------------------------------------------------------------------------
// clipped_palette_blitter_top
// palette lookup and clipped placement of a raster-order source image
// ---------------------------------------------------------------------------
// three register stages: walker, row times width product, output register
// throughput: one word per cycle unless rsp back-pressure fills the pipeline,
// loads and pixels alike; loads give no result
// the palette read and the row times width multiply each take one stage
// reset clears counters, registers and pipeline valids; palette is not cleared
// ---------------------------------------------------------------------------
module clipped_palette_blitter_top (
   input  logic                        clock,
   input  logic                        reset,

   // request stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cpb_pkg::REQ_DW-1:0]  req_tdata,  // palette_slot, palette_color, pixel_value
   input  logic                        req_tuser,  // operation

   // result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cpb_pkg::RSP_DW-1:0]  rsp_tdata,  // dest_address, pixel_color
   output logic                        rsp_tuser,  // written
   output logic                        rsp_tlast,  // image_end

   // register writes
   input  logic                        csr_we,
   input  logic [cpb_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [cpb_pkg::CSR_DW-1:0]  csr_wdata
);

   // configuration registers
   logic [cpb_pkg::DIM_W-1:0] dest_width_ff, dest_height_ff;
   logic [cpb_pkg::DIM_W-1:0] source_width_ff, source_height_ff;
   logic [cpb_pkg::OFS_W-1:0] dest_left_ff, dest_top_ff;

   // request word fields
   logic [cpb_pkg::IDX_W-1:0]   palette_slot;
   logic [cpb_pkg::COLOR_W-1:0] palette_color;
   logic [cpb_pkg::IDX_W-1:0]   pixel_value;

   logic                        req_acc, load_acc, pix_acc;
   logic                        adv;

   // saturated dimensions
   logic [cpb_pkg::DIM_W-1:0]   dw, dh, sw, sh;

   logic                        s1_valid, s1_ready;
   cpb_pkg::pix_type            s1_pix;
   logic [cpb_pkg::COLOR_W-1:0] s1_color;

   logic                        out_written, out_end;
   logic [cpb_pkg::ADDR_W-1:0]  out_address;
   logic [cpb_pkg::COLOR_W-1:0] out_color;

   assign palette_slot  = req_tdata[7:0];
   assign palette_color = req_tdata[39:8];
   assign pixel_value   = req_tdata[47:40];

   // walker stage decides whether a new word can go in
   assign req_tready = adv;
   assign req_acc    = req_tvalid && req_tready;
   assign load_acc   = req_acc && (req_tuser == cpb_pkg::OP_PALETTE_LOAD);
   assign pix_acc    = req_acc && (req_tuser == cpb_pkg::OP_PIXEL);

   assign dw = cpb_pkg::sat_dim(dest_width_ff);
   assign dh = cpb_pkg::sat_dim(dest_height_ff);
   assign sw = cpb_pkg::sat_dim(source_width_ff);
   assign sh = cpb_pkg::sat_dim(source_height_ff);

   // register writes, unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_width_ff    <= '0;
         dest_height_ff   <= '0;
         dest_left_ff     <= '0;
         dest_top_ff      <= '0;
         source_width_ff  <= '0;
         source_height_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            cpb_pkg::REG_DEST_WIDTH:    dest_width_ff    <= csr_wdata[cpb_pkg::DIM_W-1:0];
            cpb_pkg::REG_DEST_HEIGHT:   dest_height_ff   <= csr_wdata[cpb_pkg::DIM_W-1:0];
            cpb_pkg::REG_DEST_LEFT:     dest_left_ff     <= csr_wdata;
            cpb_pkg::REG_DEST_TOP:      dest_top_ff      <= csr_wdata;
            cpb_pkg::REG_SOURCE_WIDTH:  source_width_ff  <= csr_wdata[cpb_pkg::DIM_W-1:0];
            cpb_pkg::REG_SOURCE_HEIGHT: source_height_ff <= csr_wdata[cpb_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // palette: loads write at acceptance, pixels read alongside the walker stage
   cpb_palette u_palette (
      .clock    (clock),
      .wr_en    (load_acc),
      .wr_slot  (palette_slot),
      .wr_color (palette_color),
      .rd_en    (adv),
      .rd_index (pixel_value),
      .rd_color (s1_color)
   );

   // position counters and clip test
   cpb_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .pix_acc     (pix_acc),
      .s1_ready    (s1_ready),
      .dw          (dw),
      .dh          (dh),
      .sw          (sw),
      .sh          (sh),
      .dest_left   (dest_left_ff),
      .dest_top    (dest_top_ff),
      .pixel_value (pixel_value),
      .adv         (adv),
      .s1_valid    (s1_valid),
      .s1_pix      (s1_pix)
   );

   // linear address and output register
   cpb_addr u_addr (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid),
      .s1_pix      (s1_pix),
      .s1_color    (s1_color),
      .dw          (dw),
      .s1_ready    (s1_ready),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_written (out_written),
      .out_address (out_address),
      .out_color   (out_color),
      .out_end     (out_end)
   );

   assign rsp_tdata = {out_color, out_address};
   assign rsp_tuser = out_written;
   assign rsp_tlast = out_end;

endmodule

// ===== bench/tb_clipped_palette_blitter_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_clipped_palette_blitter_top
// self-checking bench for the clipped palette blitter: palette loads and
// raster pixels go in with random gaps, every result word is checked against
// an in-bench prediction of palette lookup, clipping and counter wrap
// ---------------------------------------------------------------------------
module tb_clipped_palette_blitter_top;

   localparam int PHASES        = 16;
   localparam int PHASE_WORDS   = 76;
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake at all
   localparam int SETTLE_CYCLES = 6;     // pipeline is three deep, loads give no word

   // register indexes past the last real register, writes must do nothing
   localparam logic [cpb_pkg::CSR_AW-1:0] REG_SPARE_A = 3'd6;
   localparam logic [cpb_pkg::CSR_AW-1:0] REG_SPARE_B = 3'd7;

   // one result word, fields in compare order
   typedef struct packed {
      logic                        written;
      logic [cpb_pkg::ADDR_W-1:0]  address;
      logic [cpb_pkg::COLOR_W-1:0] color;
      logic                        image_end;
   } blit_word_type;

   // palette, registers and source position as the block should hold them
   class blit_tracker_type;
      logic [cpb_pkg::COLOR_W-1:0]      palette [cpb_pkg::PAL_DEPTH];
      logic [cpb_pkg::DIM_W-1:0]        dest_width, dest_height, source_width, source_height;
      logic signed [cpb_pkg::OFS_W-1:0] dest_left, dest_top;
      int                               column, row;
      blit_word_type                    pending_pixels [$];
      int                               mismatches;

      function new();
         dest_width    = '0;
         dest_height   = '0;
         dest_left     = '0;
         dest_top      = '0;
         source_width  = '0;
         source_height = '0;
         column        = 0;
         row           = 0;
         mismatches    = 0;
      endfunction

      function void write_reg(logic [cpb_pkg::CSR_AW-1:0] index,
                              logic [cpb_pkg::CSR_DW-1:0] value);
         case (index)
            cpb_pkg::REG_DEST_WIDTH:    dest_width    = value[cpb_pkg::DIM_W-1:0];
            cpb_pkg::REG_DEST_HEIGHT:   dest_height   = value[cpb_pkg::DIM_W-1:0];
            cpb_pkg::REG_DEST_LEFT:     dest_left     = value;
            cpb_pkg::REG_DEST_TOP:      dest_top      = value;
            cpb_pkg::REG_SOURCE_WIDTH:  source_width  = value[cpb_pkg::DIM_W-1:0];
            cpb_pkg::REG_SOURCE_HEIGHT: source_height = value[cpb_pkg::DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function int clamp_dim(logic [cpb_pkg::DIM_W-1:0] v);
         return (v > cpb_pkg::DIM_W'(cpb_pkg::MAX_DIM)) ? cpb_pkg::MAX_DIM : int'(v);
      endfunction

      // palette loads update the store, pixels queue one expected word
      function void note_word(logic op, logic [cpb_pkg::IDX_W-1:0] slot,
                              logic [cpb_pkg::COLOR_W-1:0] color,
                              logic [cpb_pkg::IDX_W-1:0] index);
         blit_word_type r;
         int            sw, sh, dw, dh, ox, oy;
         if (op == cpb_pkg::OP_PALETTE_LOAD) begin
            palette[slot] = color;
            return;
         end
         sw = clamp_dim(source_width);
         sh = clamp_dim(source_height);
         dw = clamp_dim(dest_width);
         dh = clamp_dim(dest_height);
         r = '0;
         r.color = palette[index];
         if (sw == 0 || sh == 0) begin
            column = 0;
            row = 0;
            r.image_end = 1'b1;
         end else begin
            ox = int'(dest_left) + column;
            oy = int'(dest_top) + row;
            if (ox >= 0 && oy >= 0 && ox < dw && oy < dh) begin
               r.written = 1'b1;
               r.address = cpb_pkg::ADDR_W'(oy * dw + ox);
            end
            if (column + 1 >= sw) begin
               column = 0;
               if (row + 1 >= sh) begin
                  row = 0;
                  r.image_end = 1'b1;
               end else begin
                  row++;
               end
            end else begin
               column++;
            end
         end
         pending_pixels.push_back(r);
      endfunction

      function void check_word(blit_word_type got);
         blit_word_type want;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: written=%0b addr=%h color=%h end=%0b",
                        got.written, got.address, got.color, got.image_end);
            return;
         end
         want = pending_pixels.pop_front();
         if (got.written !== want.written || got.address !== want.address ||
             got.color !== want.color || got.image_end !== want.image_end) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected written=%0b addr=%h color=%h end=%0b, %s",
                        want.written, want.address, want.color, want.image_end,
                        $sformatf("got written=%0b addr=%h color=%h end=%0b",
                                  got.written, got.address, got.color, got.image_end));
         end
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // block ports, all driven from time zero
   // ------------------------------------------------------------------------
   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [cpb_pkg::REQ_DW-1:0] req_tdata  = '0;   // palette_slot, palette_color, pixel_value
   logic                       req_tuser  = 1'b0; // operation
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [cpb_pkg::RSP_DW-1:0] rsp_tdata;         // dest_address, pixel_color
   logic                       rsp_tuser;         // written
   logic                       rsp_tlast;         // image_end
   logic                       csr_we     = 1'b0;
   logic [cpb_pkg::CSR_AW-1:0] csr_addr   = '0;
   logic [cpb_pkg::CSR_DW-1:0] csr_wdata  = '0;

   clipped_palette_blitter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   blit_tracker_type          book;
   int                        send_idle_pct = 0;   // chance in a hundred of a sender gap cycle
   int                        stall_pct     = 0;   // chance in a hundred of a receiver stall cycle
   bit                        hold_request  = 1'b0;
   int                        hold_left     = 0;
   int                        quiet         = 0;
   bit                        slot_loaded [cpb_pkg::PAL_DEPTH];
   logic [cpb_pkg::IDX_W-1:0] loaded_slots [$];   // palette entries safe to read
   logic [cpb_pkg::IDX_W-1:0] corner_idx [4] = '{8'h00, 8'hFF, 8'h55, 8'hAA};

   // ------------------------------------------------------------------------
   // handshake monitor: registers, accepted words and results all sampled at
   // the edge, before any of this edge's updates land
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            book.write_reg(csr_addr, csr_wdata);
         if (req_tvalid && req_tready)
            book.note_word(req_tuser, req_tdata[7:0], req_tdata[39:8], req_tdata[47:40]);
         if (rsp_tvalid && rsp_tready)
            book.check_word({rsp_tuser, rsp_tdata[23:0], rsp_tdata[55:24], rsp_tlast});
      end
   end

   // receiver: random stalls, or a long hold-off counted here on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // driver tasks, all called just after a rising edge
   // ------------------------------------------------------------------------

   // offer one word after random gap cycles, return once it is taken;
   // valid stays high so back-to-back words need no extra edge
   task automatic send_word(input logic op, input logic [cpb_pkg::IDX_W-1:0] slot,
                            input logic [cpb_pkg::COLOR_W-1:0] color,
                            input logic [cpb_pkg::IDX_W-1:0] index);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {index, color, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_palette(input logic [cpb_pkg::IDX_W-1:0] slot,
                               input logic [cpb_pkg::COLOR_W-1:0] color);
      if (!slot_loaded[slot]) begin
         slot_loaded[slot] = 1'b1;
         loaded_slots.push_back(slot);
      end
      send_word(cpb_pkg::OP_PALETTE_LOAD, slot, color,
                cpb_pkg::IDX_W'($urandom_range(255)));
   endtask

   // slot and color fields are don't-care on a pixel word, keep them noisy
   task automatic blit_pixel(input logic [cpb_pkg::IDX_W-1:0] index);
      send_word(cpb_pkg::OP_PIXEL, cpb_pkg::IDX_W'($urandom_range(255)), $urandom, index);
   endtask

   // stop offering and wait until every expected word is back, then let
   // the pipeline settle behind any trailing palette loads
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [cpb_pkg::CSR_AW-1:0] index,
                            input logic [cpb_pkg::CSR_DW-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // all six registers, then a spare index that must not alias any of them
   task automatic program_regs(input logic [cpb_pkg::CSR_DW-1:0] dw, dh, dl, dt, sw, sh);
      write_reg(cpb_pkg::REG_DEST_WIDTH, dw);
      write_reg(cpb_pkg::REG_DEST_HEIGHT, dh);
      write_reg(cpb_pkg::REG_DEST_LEFT, dl);
      write_reg(cpb_pkg::REG_DEST_TOP, dt);
      write_reg(cpb_pkg::REG_SOURCE_WIDTH, sw);
      write_reg(cpb_pkg::REG_SOURCE_HEIGHT, sh);
      write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, cpb_pkg::CSR_DW'($urandom));
      csr_we <= 1'b0;
   endtask

   function automatic int extreme_dim();
      case ($urandom_range(5))
         0: return 0;
         1: return 1;
         2: return cpb_pkg::MAX_DIM - 1;
         3: return cpb_pkg::MAX_DIM;
         4: return cpb_pkg::MAX_DIM + 1;
         default: return 8191;
      endcase
   endfunction

   function automatic int extreme_offset();
      case ($urandom_range(5))
         0: return -8192;
         1: return -1;
         2: return 0;
         3: return 1;
         4: return cpb_pkg::MAX_DIM - 1;
         default: return 8191;
      endcase
   endfunction

   // mostly small images so they wrap often; some empty sources, some
   // placed at the far corner of a full-size frame, some extreme or raw
   task automatic random_setting();
      int roll, dw, dh, dl, dt, sw, sh;
      roll = $urandom_range(99);
      dw = $urandom_range(24);
      dh = $urandom_range(16);
      dl = int'($urandom_range(30)) - 10;
      dt = int'($urandom_range(20)) - 8;
      sw = 1 + $urandom_range(7);
      sh = 1 + $urandom_range(5);
      if (roll >= 60 && roll < 72) begin
         if ($urandom_range(1)) sw = 0;
         else sh = 0;
      end else if (roll >= 72 && roll < 84) begin
         dw = $urandom_range(1) ? cpb_pkg::MAX_DIM : 8191;
         dh = $urandom_range(1) ? cpb_pkg::MAX_DIM : 8191;
         dl = cpb_pkg::MAX_DIM - 10 + $urandom_range(9);
         dt = cpb_pkg::MAX_DIM - 8 + $urandom_range(7);
      end else if (roll >= 84 && roll < 92) begin
         dw = extreme_dim();
         dh = extreme_dim();
         sw = extreme_dim();
         sh = extreme_dim();
         dl = extreme_offset();
         dt = extreme_offset();
      end else if (roll >= 92) begin
         // raw register words, top bit of the width registers included
         dw = $urandom_range(16383);
         dh = $urandom_range(16383);
         dl = $urandom_range(16383);
         dt = $urandom_range(16383);
         sw = $urandom_range(16383);
         sh = $urandom_range(16383);
      end
      program_regs(cpb_pkg::CSR_DW'(dw), cpb_pkg::CSR_DW'(dh), cpb_pkg::CSR_DW'(dl),
                   cpb_pkg::CSR_DW'(dt), cpb_pkg::CSR_DW'(sw), cpb_pkg::CSR_DW'(sh));
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      book = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: oversized frame, source straddling the bottom-right corner,
      // so the top address and clipping on both edges show up
      program_regs(14'd8191, 14'd8191, 14'd4093, 14'd4095, 14'd4, 14'd2);
      load_palette(8'h00, 32'h0000_0000);
      load_palette(8'hFF, 32'hFFFF_FFFF);
      load_palette(8'h55, 32'hAAAA_AAAA);
      load_palette(8'hAA, 32'h5555_5555);
      for (int i = 0; i < 6; i++) blit_pixel(corner_idx[i % 4]);
      drain();

      // shrink to one pixel mid-image: counters past the bounds must wrap
      program_regs(14'd1, 14'd1, 14'd0, 14'd0, 14'd1, 14'd1);
      for (int i = 0; i < 2; i++) blit_pixel(corner_idx[i]);
      drain();

      // empty source with extreme offsets
      program_regs(14'd20, 14'd20, 14'(-8192), 14'd8191, 14'd0, 14'd5);
      for (int i = 0; i < 2; i++) blit_pixel(corner_idx[i + 2]);
      drain();

      // negative offsets, clipped on the top and left edges
      program_regs(14'd2, 14'd2, 14'(-1), 14'(-1), 14'd3, 14'd8191);
      for (int i = 0; i < 6; i++) blit_pixel(corner_idx[i % 4]);
      drain();

      // random phases, idle pattern rotates, new register setting each time
      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         random_setting();
         for (int w = 0; w < PHASE_WORDS; w++) begin
            // receiver holds off while the sender keeps pushing, fills the pipe
            if (p == 4 && w == 8)
               hold_request = 1'b1;
            // sender waits for every result mid-phase, pipe runs dry
            if (p == 6 && w == 38)
               drain();
            if ($urandom_range(99) < 20)
               load_palette(cpb_pkg::IDX_W'($urandom_range(255)), $urandom);
            else
               blit_pixel(loaded_slots[$urandom_range(loaded_slots.size() - 1)]);
         end
         drain();
      end

      if (book.mismatches == 0 && book.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
design/cpb_pkg.sv
design/cpb_palette.sv
design/cpb_walker.sv
design/cpb_addr.sv
design/clipped_palette_blitter_top.sv
bench/tb_clipped_palette_blitter_top.sv
